@@ design/rpa_pkg.sv @@
// Shared constants, types and modular arithmetic helpers for the ring polynomial ALU.
package rpa_pkg;

  localparam int unsigned CoefW         = 60;
  localparam int unsigned FieldCoefs    = 4;
  localparam int unsigned RingDegreeDef = 4;
  localparam int unsigned AddrW         = 3;
  localparam int unsigned DataW         = 64;

  typedef logic [CoefW-1:0] coef_t;
  typedef logic [AddrW-1:0] addr_t;

  localparam coef_t ModulusReset = coef_t'(12289);
  localparam addr_t RegModulus   = addr_t'(0);

  typedef enum logic [1:0] {
    FuncAdd = 2'd0,
    FuncSub = 2'd1,
    FuncMul = 2'd2,
    FuncRsv = 2'd3
  } func_e;

  // Sum of two values below q, brought back below q.
  function automatic coef_t add_mod(coef_t x, coef_t y, coef_t q);
    logic [CoefW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, q}) ? coef_t'(s - {1'b0, q}) : coef_t'(s);
  endfunction

  function automatic coef_t sub_mod(coef_t x, coef_t y, coef_t q);
    return (x >= y) ? coef_t'(x - y) : coef_t'(x + coef_t'(q - y));
  endfunction

  // One step of restoring reduction: shift in the next input bit.
  function automatic coef_t red_step(coef_t r, logic b, coef_t q);
    logic [CoefW:0] t;
    t = {r, b};
    return (t >= {1'b0, q}) ? coef_t'(t - {1'b0, q}) : coef_t'(t);
  endfunction

  // One step of MSB-first double-and-add modular multiplication.
  function automatic coef_t mul_step(coef_t r, coef_t x, logic ybit, coef_t q);
    coef_t d;
    d = add_mod(r, r, q);
    return ybit ? add_mod(d, x, q) : d;
  endfunction

endpackage

@@ design/rpa_ifs.sv @@
// Valid/ready channel interfaces for operand and result transfers.
interface rpa_in_if;
  logic                 valid;
  logic                 ready;
  rpa_pkg::func_e       func;
  rpa_pkg::coef_t       a_coef0;
  rpa_pkg::coef_t       a_coef1;
  rpa_pkg::coef_t       a_coef2;
  rpa_pkg::coef_t       a_coef3;
  rpa_pkg::coef_t       b_coef0;
  rpa_pkg::coef_t       b_coef1;
  rpa_pkg::coef_t       b_coef2;
  rpa_pkg::coef_t       b_coef3;

  modport source (output valid, func, a_coef0, a_coef1, a_coef2, a_coef3,
                  b_coef0, b_coef1, b_coef2, b_coef3, input ready);
  modport sink   (input valid, func, a_coef0, a_coef1, a_coef2, a_coef3,
                  b_coef0, b_coef1, b_coef2, b_coef3, output ready);
endinterface

interface rpa_out_if;
  logic           valid;
  logic           ready;
  rpa_pkg::coef_t c_coef0;
  rpa_pkg::coef_t c_coef1;
  rpa_pkg::coef_t c_coef2;
  rpa_pkg::coef_t c_coef3;

  modport source (output valid, c_coef0, c_coef1, c_coef2, c_coef3, input ready);
  modport sink   (input valid, c_coef0, c_coef1, c_coef2, c_coef3, output ready);
endinterface

@@ design/ring_poly_alu_mod_q.sv @@
// Top level of the pipelined polynomial ALU over Z_q[x]/(x^N+1).
//
// Operand pairs arrive on in_if (valid/ready); a transfer happens at a rising edge with
// valid and ready both high. Each transfer yields exactly one result transfer on out_if,
// holding the N coefficients of a+b, a-b or the negacyclic product a*b, all reduced mod q.
// The modulus q is written through the APB port (register 0, byte address 0); the user
// must do so only while the block is idle, and the block itself does not enforce it.
// q resets to 12289. A modulus of zero or one gives all-zero results.
// The datapath is a fully pipelined chain: 60 stages of restoring reduction bring every
// operand coefficient below q, 60 stages of bit-serial double-and-add form the N*N
// coefficient products in parallel lanes, N stages accumulate the products into the
// 2N-1 partial sums, and one last stage folds the upper half back with a minus sign.
// One operand pair can enter every cycle while the output is not stalled; the 60-bit
// reduction and multiply steps set the pipeline depth.
//
// Reset clears all stage valid bits and the output valid bit. When the receiver holds
// ready low with a result pending, the whole pipeline holds; no item is lost or repeated,
// and input is taken again as soon as the pending result is transferred.
module ring_poly_alu_mod_q #(
  parameter int unsigned RING_DEGREE = rpa_pkg::RingDegreeDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rpa_in_if.sink               in_if,
  rpa_out_if.source            out_if,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  rpa_pkg::addr_t       paddr,
  input  logic [rpa_pkg::DataW-1:0] pwdata,
  output logic [rpa_pkg::DataW-1:0] prdata,
  output logic                 pready
);
  import rpa_pkg::*;

  localparam int unsigned N  = RING_DEGREE;
  localparam int unsigned L  = 2 * N;
  localparam int unsigned P  = N * N;
  localparam int unsigned W  = CoefW;

  // Configuration register.
  coef_t q_q;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == RegModulus);
  assign prdata = (paddr == RegModulus) ? DataW'(q_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= ModulusReset;
    end else if (cfg_wr) begin
      q_q <= pwdata[W-1:0];
    end
  end

  // Global advance: the whole chain moves unless a finished result is stuck.
  logic en;
  logic ov_q;
  assign en          = !ov_q || out_if.ready;
  assign in_if.ready = en;

  // Input lanes: operand a in lanes 0..N-1, operand b in lanes N..2N-1.
  coef_t in_a [FieldCoefs];
  coef_t in_b [FieldCoefs];
  coef_t in_x [L];

  assign in_a[0] = in_if.a_coef0;
  assign in_a[1] = in_if.a_coef1;
  assign in_a[2] = in_if.a_coef2;
  assign in_a[3] = in_if.a_coef3;
  assign in_b[0] = in_if.b_coef0;
  assign in_b[1] = in_if.b_coef1;
  assign in_b[2] = in_if.b_coef2;
  assign in_b[3] = in_if.b_coef3;

  for (genvar l = 0; l < L; l++) begin : g_in
    if (l < N) begin : g_a
      if (l < FieldCoefs) begin : g_f
        assign in_x[l] = in_a[l];
      end else begin : g_z
        assign in_x[l] = '0;
      end
    end else begin : g_b
      if (l - N < FieldCoefs) begin : g_f
        assign in_x[l] = in_b[l-N];
      end else begin : g_z
        assign in_x[l] = '0;
      end
    end
  end

  // Reduction section.
  logic  rv_q [W];
  func_e rf_q [W];
  coef_t rx_q [W][L];
  coef_t rr_q [W][L];

  for (genvar t = 0; t < W; t++) begin : g_red
    logic  v_s;
    func_e f_s;
    coef_t x_s [L];
    coef_t r_s [L];

    if (t == 0) begin : g_first
      assign v_s = in_if.valid && in_if.ready;
      assign f_s = in_if.func;
      for (genvar l = 0; l < L; l++) begin : g_l
        assign x_s[l] = in_x[l];
        assign r_s[l] = '0;
      end
    end else begin : g_next
      assign v_s = rv_q[t-1];
      assign f_s = rf_q[t-1];
      for (genvar l = 0; l < L; l++) begin : g_l
        assign x_s[l] = rx_q[t-1][l];
        assign r_s[l] = rr_q[t-1][l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[t] <= 1'b0;
      end else if (en) begin
        rv_q[t] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rf_q[t] <= f_s;
        for (int l = 0; l < L; l++) begin
          rx_q[t][l] <= x_s[l];
          rr_q[t][l] <= red_step(r_s[l], x_s[l][W-1-t], q_q);
        end
      end
    end
  end

  // Multiplication section: lane i*N+j forms a[i]*b[j] mod q, MSB of b[j] first.
  logic  mv_q  [W];
  func_e mf_q  [W];
  coef_t ma_q  [W][N];
  coef_t mb_q  [W][N];
  coef_t mas_q [W][N];
  coef_t mr_q  [W][P];

  for (genvar t = 0; t < W; t++) begin : g_mul
    logic  v_s;
    func_e f_s;
    coef_t a_s  [N];
    coef_t b_s  [N];
    coef_t as_s [N];
    coef_t r_s  [P];

    if (t == 0) begin : g_first
      assign v_s = rv_q[W-1];
      assign f_s = rf_q[W-1];
      for (genvar i = 0; i < N; i++) begin : g_i
        assign a_s[i]  = rr_q[W-1][i];
        assign b_s[i]  = rr_q[W-1][N+i];
        assign as_s[i] = (rf_q[W-1] == FuncSub) ? sub_mod(a_s[i], b_s[i], q_q)
                                                : add_mod(a_s[i], b_s[i], q_q);
      end
      for (genvar p = 0; p < P; p++) begin : g_p
        assign r_s[p] = '0;
      end
    end else begin : g_next
      assign v_s = mv_q[t-1];
      assign f_s = mf_q[t-1];
      for (genvar i = 0; i < N; i++) begin : g_i
        assign a_s[i]  = ma_q[t-1][i];
        assign b_s[i]  = mb_q[t-1][i];
        assign as_s[i] = mas_q[t-1][i];
      end
      for (genvar p = 0; p < P; p++) begin : g_p
        assign r_s[p] = mr_q[t-1][p];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[t] <= 1'b0;
      end else if (en) begin
        mv_q[t] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mf_q[t] <= f_s;
        for (int i = 0; i < N; i++) begin
          ma_q[t][i]  <= a_s[i];
          mb_q[t][i]  <= b_s[i];
          mas_q[t][i] <= as_s[i];
          for (int j = 0; j < N; j++) begin
            mr_q[t][i*N+j] <= mul_step(r_s[i*N+j], a_s[i], b_s[j][W-1-t], q_q);
          end
        end
      end
    end
  end

  // Accumulation section: stage s adds the products of a[s] into the partial sums.
  logic  cv_q   [N];
  func_e cf_q   [N];
  coef_t cp_q   [N][P];
  coef_t cas_q  [N][N];
  coef_t cacc_q [N][L];

  for (genvar s = 0; s < N; s++) begin : g_acc
    logic  v_s;
    func_e f_s;
    coef_t p_s   [P];
    coef_t as_s  [N];
    coef_t acc_s [L];
    coef_t acc_d [L];

    if (s == 0) begin : g_first
      assign v_s = mv_q[W-1];
      assign f_s = mf_q[W-1];
      for (genvar p = 0; p < P; p++) begin : g_p
        assign p_s[p] = mr_q[W-1][p];
      end
      for (genvar i = 0; i < N; i++) begin : g_i
        assign as_s[i] = mas_q[W-1][i];
      end
      for (genvar k = 0; k < L; k++) begin : g_k
        assign acc_s[k] = '0;
      end
    end else begin : g_next
      assign v_s = cv_q[s-1];
      assign f_s = cf_q[s-1];
      for (genvar p = 0; p < P; p++) begin : g_p
        assign p_s[p] = cp_q[s-1][p];
      end
      for (genvar i = 0; i < N; i++) begin : g_i
        assign as_s[i] = cas_q[s-1][i];
      end
      for (genvar k = 0; k < L; k++) begin : g_k
        assign acc_s[k] = cacc_q[s-1][k];
      end
    end

    for (genvar k = 0; k < L; k++) begin : g_sum
      if (k >= s && k - s < N) begin : g_add
        assign acc_d[k] = add_mod(acc_s[k], p_s[s*N+k-s], q_q);
      end else begin : g_keep
        assign acc_d[k] = acc_s[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[s] <= 1'b0;
      end else if (en) begin
        cv_q[s] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cf_q[s] <= f_s;
        for (int p = 0; p < P; p++) begin
          cp_q[s][p] <= p_s[p];
        end
        for (int i = 0; i < N; i++) begin
          cas_q[s][i] <= as_s[i];
        end
        for (int k = 0; k < L; k++) begin
          cacc_q[s][k] <= acc_d[k];
        end
      end
    end
  end

  // Output stage: negacyclic fold for products, sum or difference otherwise, degenerate modulus and unused fields.
  coef_t oc_d [FieldCoefs];
  coef_t oc_q [FieldCoefs];
  logic  q_small;

  assign q_small = (q_q < coef_t'(2));

  for (genvar i = 0; i < FieldCoefs; i++) begin : g_out
    if (i < N) begin : g_used
      assign oc_d[i] = q_small ? '0 :
                       (cf_q[N-1] == FuncMul) ?
                         sub_mod(cacc_q[N-1][i], cacc_q[N-1][N+i], q_q) :
                         cas_q[N-1][i];
    end else begin : g_zero
      assign oc_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= cv_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < FieldCoefs; i++) begin
        oc_q[i] <= oc_d[i];
      end
    end
  end

  assign out_if.valid   = ov_q;
  assign out_if.c_coef0 = oc_q[0];
  assign out_if.c_coef1 = oc_q[1];
  assign out_if.c_coef2 = oc_q[2];
  assign out_if.c_coef3 = oc_q[3];

  // An accepted operand pair occupies the first reduction stage next cycle.
  a_in_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> rv_q[0])
    else $error("accepted operand pair did not enter the pipeline");

  // A stall freezes the stage valid bits in the middle of the chain.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (mv_q[W-1] == $past(mv_q[W-1])) && (cv_q[N-1] == $past(cv_q[N-1])))
    else $error("pipeline stage changed during a stall");

  // The last accumulation stage feeds the output register when the chain advances.
  a_out_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && cv_q[N-1]) |=> ov_q)
    else $error("finished item did not reach the output register");

endmodule
